/* rtl/core/sgoc_pkg.sv */
// shared types and constants of the site grid overlap checker
package sgoc_pkg;

    // field widths
    localparam int XW         = 24;
    localparam int DIM_W      = 20;
    localparam int TAGP_W     = 16;
    localparam int CNT_W      = 16;
    localparam int PITCH_W    = 16;
    localparam int DCOL_W     = 11;
    localparam int DROW_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // divider sizes: signed 2x+p numerator magnitude, doubled pitch divisor
    localparam int DIV_NW = XW + 2;
    localparam int DIV_DW = PITCH_W + 1;
    localparam int DIV_CW = $clog2(DIV_NW);

    // signed width of snapped coordinates and extents
    localparam int SNW = 28;

    localparam logic [CNT_W-1:0] SAT_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIE_COLS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIE_ROWS   = 2'd3;

    // register reset values
    localparam logic [PITCH_W-1:0] RST_SITE_WIDTH = 16'd1;
    localparam logic [PITCH_W-1:0] RST_ROW_HEIGHT = 16'd1;
    localparam logic [DCOL_W-1:0]  RST_DIE_COLS   = 11'd1024;
    localparam logic [DROW_W-1:0]  RST_DIE_ROWS   = 7'd64;

    // command codes
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef struct packed {
        logic start;
        logic clear;
    } grid_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [CNT_W-1:0] sites;
    } grid_sts_t;

endpackage

/* rtl/core/sgoc_if.sv */
// request and result channels of the site grid overlap checker
interface sgoc_cmd_if import sgoc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [XW-1:0]    cell_x;
    logic signed [XW-1:0]    cell_y;
    logic        [DIM_W-1:0] cell_width;
    logic        [DIM_W-1:0] cell_height;
    logic                    is_fixed;
    logic       [TAGP_W-1:0] cell_tag;

    modport source (
        output valid, command, cell_x, cell_y, cell_width, cell_height, is_fixed, cell_tag,
        input  ready
    );
    modport sink (
        input  valid, command, cell_x, cell_y, cell_width, cell_height, is_fixed, cell_tag,
        output ready
    );
endinterface

interface sgoc_res_if import sgoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              overlap_found;
    logic [CNT_W-1:0]  overlap_sites;
    logic [TAGP_W-1:0] first_owner;
    logic              out_of_range;
    logic              all_legal;

    modport source (
        output valid, overlap_found, overlap_sites, first_owner, out_of_range, all_legal,
        input  ready
    );
    modport sink (
        input  valid, overlap_found, overlap_sites, first_owner, out_of_range, all_legal,
        output ready
    );
endinterface

/* rtl/core/sgoc_divider.sv */
// restoring unsigned divider, one quotient bit per cycle
module sgoc_divider import sgoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_NW-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_NW - 1);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            rem_next = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/sgoc_grid.sv */
// occupancy memory with clearing sweep and read-modify-write rectangle walk
module sgoc_grid import sgoc_pkg::*;
#(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 1024,
    parameter int TAG_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  grid_ctl_t              ctl,
    input  logic [$clog2(GRID_COLS+1)-1:0] col_lo,
    input  logic [$clog2(GRID_COLS+1)-1:0] col_hi,
    input  logic [$clog2(GRID_ROWS+1)-1:0] row_lo,
    input  logic [$clog2(GRID_ROWS+1)-1:0] row_hi,
    input  logic [((GRID_ROWS*GRID_COLS > 1) ? $clog2(GRID_ROWS*GRID_COLS) : 1)-1:0] row_base,
    input  logic [TAG_WIDTH-1:0]   tag,
    output grid_sts_t              sts,
    output logic [TAG_WIDTH-1:0]   owner
);

    localparam int NUM_SITES = GRID_ROWS * GRID_COLS;
    localparam int AW  = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int CCW = $clog2(GRID_COLS + 1);
    localparam int RCW = $clog2(GRID_ROWS + 1);

    typedef enum logic [3:0] {
        G_CLEAR = 4'b0001,
        G_IDLE  = 4'b0010,
        G_WALK  = 4'b0100,
        G_DRAIN = 4'b1000
    } gstate_t;

    gstate_t            state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [CCW-1:0]     col_reg, col_next;
    logic [CCW-1:0]     col_lo_reg, col_lo_next;
    logic [CCW-1:0]     col_hi_reg, col_hi_next;
    logic [RCW-1:0]     row_reg, row_next;
    logic [RCW-1:0]     row_hi_reg, row_hi_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   sites_reg, sites_next;
    logic [TAG_WIDTH-1:0] owner_reg, owner_next;
    logic               done_reg, done_next;

    // one entry per site: used bit on top, owner tag below
    logic [TAG_WIDTH:0] site_mem [NUM_SITES];
    logic [TAG_WIDTH:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic [TAG_WIDTH:0] wr_data;
    logic               hit;

    always_comb
    begin
        rd_en   = (state_reg == G_WALK);
        rd_addr = base_reg + AW'(col_reg);
        hit     = pend_reg && rd_data_reg[TAG_WIDTH];

        we      = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = {1'b1, tag_reg};
        if (state_reg == G_CLEAR)
        begin
            we      = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (pend_reg && !rd_data_reg[TAG_WIDTH])
        begin
            we = 1'b1;
        end

        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        col_next       = col_reg;
        col_lo_next    = col_lo_reg;
        col_hi_next    = col_hi_reg;
        row_next       = row_reg;
        row_hi_next    = row_hi_reg;
        base_next      = base_reg;
        tag_next       = tag_reg;
        pend_next      = (state_reg == G_WALK);
        pend_addr_next = rd_addr;
        found_next     = found_reg;
        sites_next     = sites_reg;
        owner_next     = owner_reg;
        done_next      = 1'b0;

        // conflict bookkeeping for the site read in the previous cycle
        if (hit)
        begin
            found_next = 1'b1;
            if (!found_reg)
                owner_next = rd_data_reg[TAG_WIDTH-1:0];
            if (sites_reg != SAT_MAX)
                sites_next = sites_reg + 1'b1;
        end

        case (state_reg)
            G_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(NUM_SITES - 1))
                begin
                    state_next = G_IDLE;
                    done_next  = 1'b1;
                end
            end
            G_IDLE:
            begin
                if (ctl.start)
                begin
                    found_next = 1'b0;
                    sites_next = '0;
                    owner_next = '0;
                    if (ctl.clear)
                    begin
                        state_next    = G_CLEAR;
                        clr_addr_next = '0;
                    end
                    else
                    begin
                        state_next  = G_WALK;
                        col_next    = col_lo;
                        col_lo_next = col_lo;
                        col_hi_next = col_hi;
                        row_next    = row_lo;
                        row_hi_next = row_hi;
                        base_next   = row_base;
                        tag_next    = tag;
                    end
                end
            end
            G_WALK:
            begin
                if (col_reg == col_hi_reg)
                begin
                    col_next  = col_lo_reg;
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + AW'(GRID_COLS);
                    if (row_reg == row_hi_reg)
                        state_next = G_DRAIN;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            G_DRAIN:
            begin
                // last read is settled this cycle
                state_next = G_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= G_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            sites_reg    <= '0;
            owner_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            sites_reg    <= sites_next;
            owner_reg    <= owner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        col_lo_reg    <= col_lo_next;
        col_hi_reg    <= col_hi_next;
        row_reg       <= row_next;
        row_hi_reg    <= row_hi_next;
        base_reg      <= base_next;
        tag_reg       <= tag_next;
        pend_addr_reg <= pend_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            site_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= site_mem[rd_addr];
    end

    assign sts.busy  = (state_reg != G_IDLE);
    assign sts.done  = done_reg;
    assign sts.found = found_reg;
    assign sts.sites = sites_reg;
    assign owner     = owner_reg;

endmodule

/* rtl/core/site_grid_overlap_checker.sv */
// top level: snaps each cell to the site grid and claims its sites
// a check request runs four serial divisions, then clipping, then, unless rejected or
//   empty, a walk of the memory over the covered sites; requests are taken one at a time
// a clear request sweeps every site of the grid
// reset: control cleared, then a clearing pass over every site of the grid
//   with cmd.ready low; configuration writes are taken throughout
module site_grid_overlap_checker import sgoc_pkg::*;
#(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 1024,
    parameter int TAG_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sgoc_cmd_if.sink              cmd,
    sgoc_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NUM_SITES = GRID_ROWS * GRID_COLS;
    localparam int AW  = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int CCW = $clog2(GRID_COLS + 1);
    localparam int RCW = $clog2(GRID_ROWS + 1);

    // one-hot sequencer: accept, divide four times, clip, launch the walk, deliver; a clear goes straight to the grid
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DGO    = 7'b0000010,
        ST_DWAIT  = 7'b0000100,
        ST_CLIP   = 7'b0001000,
        ST_LAUNCH = 7'b0010000,
        ST_GRID   = 7'b0100000,
        ST_HOLD   = 7'b1000000
    } state_t;

    // the four divisions, in issue order
    typedef enum logic [1:0] {
        OP_X0 = 2'd0,
        OP_Y0 = 2'd1,
        OP_XS = 2'd2,
        OP_YS = 2'd3
    } div_op_t;

    // configuration registers
    logic [PITCH_W-1:0] site_width_reg;
    logic [PITCH_W-1:0] row_height_reg;
    logic [DCOL_W-1:0]  die_cols_reg;
    logic [DROW_W-1:0]  die_rows_reg;

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;

    // captured request
    logic                    cmd_reg;
    logic signed [XW-1:0]    cx_reg;
    logic signed [XW-1:0]    cy_reg;
    logic        [DIM_W-1:0] cw_reg;
    logic        [DIM_W-1:0] ch_reg;
    logic                    fixed_reg;
    logic       [TAGP_W-1:0] tag_reg;

    // snapped geometry
    logic signed [SNW-1:0] x0_reg, x0_next;
    logic signed [SNW-1:0] y0_reg, y0_next;
    logic signed [SNW-1:0] xs_reg, xs_next;
    logic signed [SNW-1:0] ys_reg, ys_next;
    logic                  neg_reg, neg_next;
    logic [CCW-1:0]        col_lo_reg, col_lo_next;
    logic [CCW-1:0]        col_hi_reg, col_hi_next;
    logic [RCW-1:0]        row_lo_reg, row_lo_next;
    logic [RCW-1:0]        row_hi_reg, row_hi_next;
    logic                  oor_reg, oor_next;
    logic                  go_reg, go_next;
    logic                  walk_reg, walk_next;

    // result register and running pass flag
    logic              res_valid_reg, res_valid_next;
    logic              res_found_reg, res_found_next;
    logic [CNT_W-1:0]  res_sites_reg, res_sites_next;
    logic [TAGP_W-1:0] res_owner_reg, res_owner_next;
    logic              res_oor_reg, res_oor_next;
    logic              pass_reg, pass_next;

    // divider hookup
    logic              div_start;
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_DW-1:0] div_divisor;
    logic              div_done;
    logic [DIV_NW-1:0] div_q;
    logic [DIV_DW-1:0] div_r;

    // grid hookup
    grid_ctl_t            grid_ctl;
    grid_sts_t            grid_sts;
    logic [AW-1:0]        row_base;
    logic [TAG_WIDTH-1:0] grid_owner;

    // working values
    logic                  accept;
    logic [PITCH_W-1:0]    sw_eff;
    logic [PITCH_W-1:0]    rh_eff;
    logic [DIV_NW-1:0]     num;
    logic                  is_round;
    logic [SNW-1:0]        up;
    logic signed [SNW-1:0] val;
    logic signed [SNW-1:0] dc_s;
    logic signed [SNW-1:0] dr_s;
    logic signed [SNW-1:0] x1_s;
    logic signed [SNW-1:0] y1_s;
    logic signed [SNW-1:0] x0c;
    logic signed [SNW-1:0] y0c;
    logic signed [SNW-1:0] x1c;
    logic signed [SNW-1:0] y1c;
    logic                  bad;
    logic                  out_free;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && !grid_sts.busy;
    assign out_free  = !res_valid_reg || res.ready;

    // zero pitch counts as one
    assign sw_eff = (site_width_reg == '0) ? PITCH_W'(1) : site_width_reg;
    assign rh_eff = (row_height_reg == '0) ? PITCH_W'(1) : row_height_reg;

    // configuration writes, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_width_reg <= RST_SITE_WIDTH;
            row_height_reg <= RST_ROW_HEIGHT;
            die_cols_reg   <= RST_DIE_COLS;
            die_rows_reg   <= RST_DIE_ROWS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SITE_WIDTH: site_width_reg <= cfg_wdata;
                CFG_ROW_HEIGHT: row_height_reg <= cfg_wdata;
                CFG_DIE_COLS:   die_cols_reg   <= cfg_wdata[DCOL_W-1:0];
                CFG_DIE_ROWS:   die_rows_reg   <= cfg_wdata[DROW_W-1:0];
                default:        ;
            endcase
        end
    end

    // divider operands: rounding uses floor((2v + p) / 2p), sizes use a ceiling
    always_comb
    begin
        is_round     = (op_reg == OP_X0) || (op_reg == OP_Y0);
        num          = '0;
        div_divisor  = {1'b0, sw_eff};
        case (op_reg)
            OP_X0:
            begin
                num         = {cx_reg[XW-1], cx_reg, 1'b0} + DIV_NW'(sw_eff);
                div_divisor = {sw_eff, 1'b0};
            end
            OP_Y0:
            begin
                num         = {cy_reg[XW-1], cy_reg, 1'b0} + DIV_NW'(rh_eff);
                div_divisor = {rh_eff, 1'b0};
            end
            OP_XS:
            begin
                num         = DIV_NW'(cw_reg);
                div_divisor = {1'b0, sw_eff};
            end
            OP_YS:
            begin
                num         = DIV_NW'(ch_reg);
                div_divisor = {1'b0, rh_eff};
            end
            default:
            begin
                num = '0;
            end
        endcase
        // magnitude for the unsigned divider; floor of a negative is fixed up after
        neg_next     = is_round && num[DIV_NW-1];
        div_dividend = neg_next ? (~num + 1'b1) : num;
        div_start    = (state_reg == ST_DGO);

        up  = SNW'(div_q) + SNW'(div_r != '0);
        if (!is_round)
            val = up;
        else if (neg_reg)
            val = -up;
        else
            val = SNW'(div_q);
    end

    // die limits and clipping
    always_comb
    begin
        dc_s = (SNW'(die_cols_reg) < SNW'(GRID_COLS)) ? SNW'(die_cols_reg) : SNW'(GRID_COLS);
        dr_s = (SNW'(die_rows_reg) < SNW'(GRID_ROWS)) ? SNW'(die_rows_reg) : SNW'(GRID_ROWS);
        x1_s = x0_reg + xs_reg;
        y1_s = y0_reg + ys_reg;
        if (fixed_reg)
        begin
            // fixed cell: raise origin to zero, cut extent at the die
            x0c = x0_reg[SNW-1] ? SNW'(0) : x0_reg;
            y0c = y0_reg[SNW-1] ? SNW'(0) : y0_reg;
            x1c = (x1_s > dc_s) ? dc_s : x1_s;
            y1c = (y1_s > dr_s) ? dr_s : y1_s;
            bad = 1'b0;
        end
        else
        begin
            // movable cell: any bad origin, empty size or die spill rejects it
            x0c = x0_reg;
            y0c = y0_reg;
            x1c = x1_s;
            y1c = y1_s;
            bad = x0_reg[SNW-1] || y0_reg[SNW-1] || (xs_reg == SNW'(0)) ||
                  (ys_reg == SNW'(0)) || (x1_s > dc_s) || (y1_s > dr_s);
        end
    end

    // first site row of the rectangle in linear address space
    assign row_base = AW'(32'(row_lo_reg) * 32'(GRID_COLS));

    assign grid_ctl.start = (accept && (cmd.command == CMD_CLEAR)) ||
                            ((state_reg == ST_LAUNCH) && go_reg);
    assign grid_ctl.clear = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        col_lo_next    = col_lo_reg;
        col_hi_next    = col_hi_reg;
        row_lo_next    = row_lo_reg;
        row_hi_next    = row_hi_reg;
        oor_next       = oor_reg;
        go_next        = go_reg;
        walk_next      = walk_reg;
        pass_next      = pass_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_found_next = res_found_reg;
        res_sites_next = res_sites_reg;
        res_owner_next = res_owner_reg;
        res_oor_next   = res_oor_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    oor_next  = 1'b0;
                    walk_next = 1'b0;
                    op_next   = OP_X0;
                    if (cmd.command == CMD_CLEAR)
                        state_next = ST_GRID;
                    else
                        state_next = ST_DGO;
                end
            end
            ST_DGO:
            begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    case (op_reg)
                        OP_X0:   x0_next = val;
                        OP_Y0:   y0_next = val;
                        OP_XS:   xs_next = val;
                        OP_YS:   ys_next = val;
                        default: ;
                    endcase
                    if (op_reg == OP_YS)
                    begin
                        state_next = ST_CLIP;
                    end
                    else
                    begin
                        op_next    = div_op_t'(op_reg + 1'b1);
                        state_next = ST_DGO;
                    end
                end
            end
            ST_CLIP:
            begin
                oor_next    = bad;
                go_next     = !bad && (x0c < x1c) && (y0c < y1c);
                col_lo_next = CCW'(x0c);
                col_hi_next = CCW'(x1c - 1);
                row_lo_next = RCW'(y0c);
                row_hi_next = RCW'(y1c - 1);
                state_next  = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                walk_next  = go_reg;
                state_next = go_reg ? ST_GRID : ST_HOLD;
            end
            ST_GRID:
            begin
                if (grid_sts.done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                // result waits here only while the output register is full and res.ready is low
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = walk_reg && grid_sts.found;
                    res_sites_next = walk_reg ? grid_sts.sites : '0;
                    res_owner_next = walk_reg ? TAGP_W'(grid_owner) : '0;
                    res_oor_next   = oor_reg;
                    if (cmd_reg == CMD_CLEAR)
                        pass_next = 1'b1;
                    else if (walk_reg && grid_sts.found)
                        pass_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_X0;
            oor_reg       <= 1'b0;
            go_reg        <= 1'b0;
            walk_reg      <= 1'b0;
            pass_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            oor_reg       <= oor_next;
            go_reg        <= go_next;
            walk_reg      <= walk_next;
            pass_reg      <= pass_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd.command;
            cx_reg    <= cmd.cell_x;
            cy_reg    <= cmd.cell_y;
            cw_reg    <= cmd.cell_width;
            ch_reg    <= cmd.cell_height;
            fixed_reg <= cmd.is_fixed;
            tag_reg   <= cmd.cell_tag;
        end
        if (state_reg == ST_DGO)
            neg_reg <= neg_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        xs_reg        <= xs_next;
        ys_reg        <= ys_next;
        col_lo_reg    <= col_lo_next;
        col_hi_reg    <= col_hi_next;
        row_lo_reg    <= row_lo_next;
        row_hi_reg    <= row_hi_next;
        res_found_reg <= res_found_next;
        res_sites_reg <= res_sites_next;
        res_owner_reg <= res_owner_next;
        res_oor_reg   <= res_oor_next;
    end

    sgoc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    sgoc_grid #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_grid (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (grid_ctl),
        .col_lo   (col_lo_reg),
        .col_hi   (col_hi_reg),
        .row_lo   (row_lo_reg),
        .row_hi   (row_hi_reg),
        .row_base (row_base),
        .tag      (TAG_WIDTH'(tag_reg)),
        .sts      (grid_sts),
        .owner    (grid_owner)
    );

    assign res.valid         = res_valid_reg;
    assign res.overlap_found = res_found_reg;
    assign res.overlap_sites = res_sites_reg;
    assign res.first_owner   = res_owner_reg;
    assign res.out_of_range  = res_oor_reg;
    assign res.all_legal     = pass_reg;

endmodule
